// ===== rtl/sallru_pkg.sv =====
// ----------------------------------------------------------------------------
// Set-associative LRU lookup package
// Field widths, default sizes and the result type that the lookup unit and its
// channel interfaces share.
// ----------------------------------------------------------------------------
package sallru_pkg;

  // Fixed widths of the request and response fields.
  localparam int unsigned SET_INDEX_W = 6;
  localparam int unsigned TAG_IN_W    = 24;
  localparam int unsigned OUTCOME_W   = 2;
  localparam int unsigned WAY_OUT_W   = 2;

  // Default geometry of the cache directory.
  localparam int unsigned SETS_DEF     = 64;
  localparam int unsigned WAYS_DEF     = 4;
  localparam int unsigned TAG_BITS_DEF = 24;

  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_HIT      = 2'd0,
    OUTCOME_COLD     = 2'd1,
    OUTCOME_CONFLICT = 2'd2
  } outcome_e;

  typedef struct packed {
    outcome_e               outcome;
    logic [WAY_OUT_W-1:0]   way;
  } sallru_result_t;

endpackage

// ===== rtl/sallru_if.sv =====
// ----------------------------------------------------------------------------
// Set-associative LRU lookup channels
// Valid/ready request and response channels of the lookup unit.
// ----------------------------------------------------------------------------
interface sallru_req_if;
  import sallru_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SET_INDEX_W-1:0] set_index;
  logic [TAG_IN_W-1:0]    tag;

  modport source (output valid, output set_index, output tag, input ready);
  modport sink   (input valid, input set_index, input tag, output ready);
endinterface

interface sallru_rsp_if;
  import sallru_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [WAY_OUT_W-1:0] way;

  modport source (output valid, output outcome, output way, input ready);
  modport sink   (input valid, input outcome, input way, output ready);
endinterface

// ===== rtl/sallru_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read; the read data
// holds while no read is enabled.
// ----------------------------------------------------------------------------
module sallru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sallru_way_sel.sv =====
// ----------------------------------------------------------------------------
// Set-associative LRU way selection
// Compares the tag against every way of one set row, picks the hit, cold or
// victim way and produces the updated row with that way made most recent.
// ----------------------------------------------------------------------------
module sallru_way_sel #(
  parameter int unsigned WAYS     = sallru_pkg::WAYS_DEF,
  parameter int unsigned TAG_BITS = sallru_pkg::TAG_BITS_DEF,
  localparam int unsigned WB      = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [TAG_BITS-1:0]           tag_i,
  input  logic [WAYS-1:0]               valid_i,
  input  logic [WAYS-1:0][TAG_BITS-1:0] tags_i,
  input  logic [WAYS-1:0][WB-1:0]       ranks_i,
  output logic [WAYS-1:0]               valid_o,
  output logic [WAYS-1:0][TAG_BITS-1:0] tags_o,
  output logic [WAYS-1:0][WB-1:0]       ranks_o,
  output sallru_pkg::sallru_result_t    result_o
);
  import sallru_pkg::*;

  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] lru_vec;
  logic [WB-1:0]   hit_way;
  logic [WB-1:0]   inv_way;
  logic [WB-1:0]   lru_way;
  logic [WB-1:0]   chosen;
  logic [WB-1:0]   old_rank;
  outcome_e        outcome;

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = valid_i[w] && (tags_i[w] == tag_i);
      lru_vec[w] = (ranks_i[w] == '0);
    end
    // Descending scan so that the lowest matching way wins.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WB'(w);
      end
      if (!valid_i[w]) begin
        inv_way = WB'(w);
      end
      if (lru_vec[w]) begin
        lru_way = WB'(w);
      end
    end

    if (|hit_vec) begin
      outcome = OUTCOME_HIT;
      chosen  = hit_way;
    end else if (!(&valid_i)) begin
      outcome = OUTCOME_COLD;
      chosen  = inv_way;
    end else begin
      outcome = OUTCOME_CONFLICT;
      chosen  = lru_way;
    end

    old_rank = ranks_i[chosen];

    for (int w = 0; w < WAYS; w++) begin
      valid_o[w] = valid_i[w];
      tags_o[w]  = tags_i[w];
      if (WB'(w) == chosen) begin
        ranks_o[w] = WB'(WAYS - 1);
        if (outcome != OUTCOME_HIT) begin
          valid_o[w] = 1'b1;
          tags_o[w]  = tag_i;
        end
      end else if (ranks_i[w] > old_rank) begin
        ranks_o[w] = ranks_i[w] - 1'b1;
      end else begin
        ranks_o[w] = ranks_i[w];
      end
    end

    result_o.outcome = outcome;
    result_o.way     = WAY_OUT_W'(chosen);
  end

endmodule

// ===== rtl/set_assoc_lru_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache lookup with true LRU replacement
// Keeps valid bits, tags and recency ranks per set in one RAM and answers each
// request with hit, cold miss or conflict miss and the way used.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_i carrying a set index and a tag; each request
// yields exactly one response on rsp_o with the outcome and the way that was
// hit or filled. Both channels use a valid/ready handshake.
// The whole directory row of a set (valid bits, tags and ranks of all ways)
// sits in one RAM word. A request is read from the RAM at the edge that
// accepts it; in the update state the row is updated and written back and
// the response is loaded into the output register, once that register is
// free. A new request is accepted only after the previous one has been
// written back, set by this read-modify-write of a single row.
// After reset the unit runs a clearing pass over all SETS rows, writing one
// empty row per cycle with ranks equal to the way index; req_i.ready stays
// low meanwhile. A stalled response waits in the output register, and the
// next request can still be accepted; the unit only holds its update while
// the output register is occupied and not being drained.
// ----------------------------------------------------------------------------
module set_assoc_lru_lookup_unit #(
  parameter int unsigned SETS     = sallru_pkg::SETS_DEF,
  parameter int unsigned WAYS     = sallru_pkg::WAYS_DEF,
  parameter int unsigned TAG_BITS = sallru_pkg::TAG_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sallru_req_if.sink   req_i,
  sallru_rsp_if.source rsp_o
);
  import sallru_pkg::*;

  localparam int unsigned SET_AW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WB        = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W     = WAYS * (1 + TAG_BITS + WB);
  localparam int unsigned SET_IDX_N = 2 ** SET_INDEX_W;
  localparam int unsigned TAG_EXT_W = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_e;

  state_e          state_q, state_d;
  logic [SET_AW-1:0] clr_idx_q, clr_idx_d;
  logic [SET_AW-1:0] set_q, set_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic            out_valid_q, out_valid_d;
  sallru_result_t  out_res_q, out_res_d;

  // Set index wrapped modulo SETS through a constant table.
  logic [SET_AW-1:0] set_wrap [SET_IDX_N];
  for (genvar i = 0; i < SET_IDX_N; i++) begin : g_wrap
    assign set_wrap[i] = SET_AW'(i % SETS);
  end

  logic [TAG_EXT_W-1:0] tag_ext;
  logic [TAG_BITS-1:0]  tag_in;
  assign tag_ext = TAG_EXT_W'(req_i.tag);
  assign tag_in  = tag_ext[TAG_BITS-1:0];

  // RAM port signals.
  logic              ram_we, ram_re;
  logic [SET_AW-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;

  sallru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Row layout, from the low end: valid bits, tags, ranks.
  logic [WAYS-1:0]               rd_valid, nx_valid;
  logic [WAYS-1:0][TAG_BITS-1:0] rd_tags, nx_tags;
  logic [WAYS-1:0][WB-1:0]       rd_ranks, nx_ranks, init_ranks;
  sallru_result_t                sel_res;

  assign rd_valid = ram_rdata[WAYS-1:0];
  assign rd_tags  = ram_rdata[WAYS*(1+TAG_BITS)-1:WAYS];
  assign rd_ranks = ram_rdata[ROW_W-1:WAYS*(1+TAG_BITS)];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      init_ranks[w] = WB'(w);
    end
  end

  sallru_way_sel #(
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_way_sel (
    .tag_i    (tag_q),
    .valid_i  (rd_valid),
    .tags_i   (rd_tags),
    .ranks_i  (rd_ranks),
    .valid_o  (nx_valid),
    .tags_o   (nx_tags),
    .ranks_o  (nx_ranks),
    .result_o (sel_res)
  );

  logic out_free;
  logic req_acc;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    set_d       = set_q;
    tag_d       = tag_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = set_q;
    ram_wdata   = {nx_ranks, nx_tags, nx_valid};
    ram_re      = 1'b0;
    ram_raddr   = set_wrap[req_i.set_index];

    unique case (state_q)
      ST_CLEAR: begin
        // Empty row with identity ranks; tags are written as zero.
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = {init_ranks, {(WAYS*TAG_BITS){1'b0}}, {WAYS{1'b0}}};
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == SET_AW'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_acc) begin
          ram_re  = 1'b1;
          set_d   = set_wrap[req_i.set_index];
          tag_d   = tag_in;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // The RAM holds its read data while the update waits for the output.
        if (out_free) begin
          ram_we      = 1'b1;
          out_valid_d = 1'b1;
          out_res_d   = sel_res;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q     <= set_d;
    tag_q     <= tag_d;
    out_res_q <= out_res_d;
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.outcome = out_res_q.outcome;
  assign rsp_o.way     = out_res_q.way;

  // Rank vectors used by the checks below.
  logic [WAYS-1:0] lru_vec, mru_vec;
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      lru_vec[w] = (rd_ranks[w] == '0);
      mru_vec[w] = (nx_ranks[w] == WB'(WAYS - 1));
    end
  end

  // A completed update always leaves a response and returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) && out_free |=> out_valid_q && (state_q == ST_IDLE))
    else $error("update did not produce a response");

  // A row read for an update has exactly one least recent way (rank zero).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> $onehot(lru_vec))
    else $error("row read without a unique least recent way");

  // Exactly one way is most recent in every row written back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) && out_free |-> $onehot(mru_vec))
    else $error("row written without a unique most recent way");

  // A response that is stalled keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready |=> $stable(out_res_q))
    else $error("stalled response changed");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the set-associative LRU lookup unit
// Drives requests through the request channel and checks every response
// against the answer in its directed row or a behavioural copy of the cache
// directory with true LRU replacement. A directed table comes first, then
// random traffic under four patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sallru_pkg::*;

  localparam int unsigned NSETS      = SETS_DEF;
  localparam int unsigned NWAYS      = WAYS_DEF;
  localparam int unsigned RANK_W     = $clog2(NWAYS);
  localparam int          HALF_CLK   = 6;
  localparam int          CYCLE_CAP  = 300000;
  localparam int          PHASE_REQS = 250;
  localparam int          POOL_TAGS  = 6;

  // One row of the directed table. Where typed is set, the expected response
  // is given in the row itself; otherwise the directory copy supplies it.
  typedef struct packed {
    logic [SET_INDEX_W-1:0] set_index;
    logic [TAG_IN_W-1:0]    tag;
    bit                     typed;
    outcome_e               outcome;
    logic [WAY_OUT_W-1:0]   way;
  } directed_row_t;

  localparam int N_DIRECTED = 23;

  // Set 0 is filled, hit, then overflowed so that the oldest line is evicted.
  // Set 63 carries the all-ones tag. Sets 42 and 21 alternate with opposite
  // bit patterns, and sets 0 and 63 are requested back to back, so the
  // read-modify-write hazard is exercised from the very first requests.
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{6'd0,  24'h000000, 1'b1, OUTCOME_COLD,     2'd0},
    '{6'd0,  24'h000000, 1'b1, OUTCOME_HIT,      2'd0},
    '{6'd0,  24'hFFFFFF, 1'b1, OUTCOME_COLD,     2'd1},
    '{6'd0,  24'h000001, 1'b1, OUTCOME_COLD,     2'd2},
    '{6'd0,  24'h000002, 1'b1, OUTCOME_COLD,     2'd3},
    '{6'd0,  24'h000003, 1'b1, OUTCOME_CONFLICT, 2'd0},
    '{6'd0,  24'h000000, 1'b0, OUTCOME_HIT,      2'd0},
    '{6'd0,  24'hFFFFFF, 1'b0, OUTCOME_HIT,      2'd0},
    '{6'd0,  24'h000003, 1'b0, OUTCOME_HIT,      2'd0},
    '{6'd63, 24'hFFFFFF, 1'b1, OUTCOME_COLD,     2'd0},
    '{6'd63, 24'hABCDEF, 1'b1, OUTCOME_COLD,     2'd1},
    '{6'd63, 24'hFFFFFF, 1'b1, OUTCOME_HIT,      2'd0},
    '{6'd63, 24'h543210, 1'b0, OUTCOME_HIT,      2'd0},
    '{6'd63, 24'h000000, 1'b0, OUTCOME_HIT,      2'd0},
    '{6'd63, 24'hABCDEF, 1'b0, OUTCOME_HIT,      2'd0},
    '{6'd63, 24'h123456, 1'b0, OUTCOME_HIT,      2'd0},
    '{6'd42, 24'h555555, 1'b1, OUTCOME_COLD,     2'd0},
    '{6'd21, 24'hAAAAAA, 1'b1, OUTCOME_COLD,     2'd0},
    '{6'd42, 24'hAAAAAA, 1'b0, OUTCOME_HIT,      2'd0},
    '{6'd21, 24'h555555, 1'b0, OUTCOME_HIT,      2'd0},
    '{6'd42, 24'h555555, 1'b0, OUTCOME_HIT,      2'd0},
    '{6'd21, 24'hAAAAAA, 1'b0, OUTCOME_HIT,      2'd0},
    '{6'd0,  24'h000001, 1'b0, OUTCOME_HIT,      2'd0}
  };

  logic clk_i;
  logic rst_ni;

  sallru_req_if req_if ();
  sallru_rsp_if rsp_if ();

  set_assoc_lru_lookup_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Private copy of the cache directory, updated once per accepted request.
  logic                line_ok   [NSETS][NWAYS];
  logic [TAG_IN_W-1:0] line_addr [NSETS][NWAYS];
  logic [RANK_W-1:0]   line_age  [NSETS][NWAYS];

  // Responses still owed by the unit, oldest first.
  sallru_result_t owed_rsp_q [$];

  int src_idle_pct;
  int snk_stall_pct;
  int n_mismatch;
  int n_requests;
  int n_hit;
  int n_cold;
  int n_conflict;
  int n_cycles;

  // The clock starts low, so the first rising edge falls at half a period.
  initial clk_i = 1'b0;
  always #HALF_CLK clk_i = ~clk_i;

  // Empties the directory copy: every line invalid and the rank of each way
  // equal to its index, so way 0 is the first victim in every set.
  task automatic clear_directory();
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        line_ok[s][w]   = 1'b0;
        line_addr[s][w] = '0;
        line_age[s][w]  = RANK_W'(w);
      end
    end
  endtask

  // Looks the tag up in the set and applies the access to the directory copy.
  // A valid matching way is a hit; failing that, the lowest invalid way is
  // filled as a cold miss; failing that, the way with the lowest rank (the
  // lowest index among equals) is replaced as a conflict miss. Whatever way
  // is used then moves to the top rank and the ways above its old rank each
  // drop by one.
  function automatic sallru_result_t lru_access(input logic [SET_INDEX_W-1:0] s,
                                                input logic [TAG_IN_W-1:0] t);
    sallru_result_t    r;
    int                pick;
    bit                found;
    logic [RANK_W-1:0] old_age;
    pick  = 0;
    found = 1'b0;
    for (int w = 0; w < NWAYS; w++) begin
      if (!found && line_ok[s][w] && line_addr[s][w] == t) begin
        pick  = w;
        found = 1'b1;
      end
    end
    if (found) begin
      r.outcome = OUTCOME_HIT;
    end else begin
      for (int w = 0; w < NWAYS; w++) begin
        if (!found && !line_ok[s][w]) begin
          pick  = w;
          found = 1'b1;
        end
      end
      if (found) begin
        r.outcome = OUTCOME_COLD;
      end else begin
        pick = 0;
        for (int w = 1; w < NWAYS; w++) begin
          if (line_age[s][w] < line_age[s][pick]) pick = w;
        end
        r.outcome = OUTCOME_CONFLICT;
      end
      line_ok[s][pick]   = 1'b1;
      line_addr[s][pick] = t;
    end
    old_age = line_age[s][pick];
    for (int w = 0; w < NWAYS; w++) begin
      if (line_age[s][w] > old_age) line_age[s][w] = line_age[s][w] - 1'b1;
    end
    line_age[s][pick] = RANK_W'(NWAYS - 1);
    r.way = WAY_OUT_W'(pick);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Offers one request, starting and ending at a falling edge. The source may
  // first idle for random cycles; valid is then held until the unit takes the
  // request, at which point the expected response is recorded. Valid is not
  // lowered after the handshake, so consecutive requests can follow without a gap.
  task automatic send_request(input logic [SET_INDEX_W-1:0] s,
                              input logic [TAG_IN_W-1:0] t,
                              input bit typed,
                              input sallru_result_t typed_rsp);
    sallru_result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.set_index <= s;
    req_if.tag       <= t;
    do @(posedge clk_i); while (!req_if.ready);
    // The directory copy is always updated, even where the row gives the
    // answer, so that later rows and random requests see the right state.
    r = lru_access(s, t);
    owed_rsp_q.push_back(typed ? typed_rsp : r);
    n_requests++;
    @(negedge clk_i);
  endtask

  // The sink stalls at random according to the current phase.
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Each response taken from the unit is checked against the oldest request
  // still owed, one field at a time.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (owed_rsp_q.size() == 0) begin
        report_mismatch($sformatf("response (outcome %0d, way %0d) with no request owed",
                                  rsp_if.outcome, rsp_if.way));
      end else begin
        if (rsp_if.outcome !== owed_rsp_q[0].outcome) begin
          report_mismatch($sformatf("outcome %0d, expected %0d",
                                    rsp_if.outcome, owed_rsp_q[0].outcome));
        end
        if (rsp_if.way !== owed_rsp_q[0].way) begin
          report_mismatch($sformatf("way %0d, expected %0d",
                                    rsp_if.way, owed_rsp_q[0].way));
        end
        case (owed_rsp_q[0].outcome)
          OUTCOME_HIT:      n_hit++;
          OUTCOME_COLD:     n_cold++;
          OUTCOME_CONFLICT: n_conflict++;
          default: ;
        endcase
        void'(owed_rsp_q.pop_front());
      end
    end
  end

  // Watchdog: the cap allows for the clearing pass after reset and for the
  // slowest phases, where one side holds off most of the time, many times
  // over.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               n_cycles, owed_rsp_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [TAG_IN_W-1:0]    tag_pool [POOL_TAGS];
    logic [SET_INDEX_W-1:0] hot_base;
    logic [SET_INDEX_W-1:0] s;
    logic [TAG_IN_W-1:0]    t;
    sallru_result_t         typed_rsp;
    int                     idle_by_phase  [4];
    int                     stall_by_phase [4];
    int                     roll;
    idle_by_phase  = '{0, 86, 0, 8};
    stall_by_phase = '{0, 0, 86, 8};
    n_mismatch       = 0;
    n_requests       = 0;
    n_hit            = 0;
    n_cold           = 0;
    n_conflict       = 0;
    n_cycles         = 0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.set_index = '0;
    req_if.tag       = '0;
    rsp_if.ready     = 1'b0;
    clear_directory();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: the unit holds off requests during its clearing pass,
    // so the first row simply waits for the handshake.
    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_rsp.outcome = DIRECTED[i].outcome;
      typed_rsp.way     = DIRECTED[i].way;
      send_request(DIRECTED[i].set_index, DIRECTED[i].tag, DIRECTED[i].typed, typed_rsp);
    end

    // Random part. Most requests go to a handful of neighbouring sets with
    // tags from a small pool, a little larger than the number of ways, so
    // hits, cold fills and evictions all occur often. The rest use fully
    // random sets and tags, which toggle every bit of both fields.
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = idle_by_phase[ph];
      snk_stall_pct = stall_by_phase[ph];
      hot_base      = SET_INDEX_W'($urandom_range(NSETS - 1));
      foreach (tag_pool[k]) tag_pool[k] = TAG_IN_W'($urandom);
      for (int i = 0; i < PHASE_REQS; i++) begin
        roll = $urandom_range(99);
        if (roll < 85) begin
          s = hot_base + SET_INDEX_W'($urandom_range(3));
          t = (roll < 70) ? tag_pool[$urandom_range(POOL_TAGS - 1)] : TAG_IN_W'($urandom);
        end else begin
          s = SET_INDEX_W'($urandom);
          t = TAG_IN_W'($urandom);
        end
        send_request(s, t, 1'b0, typed_rsp);
      end
    end
    req_if.valid <= 1'b0;

    // Drain whatever is still owed, then give the unit a few more cycles so
    // that any stray response would be caught.
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    while (owed_rsp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d requests in %0d cycles: %0d hits, %0d cold misses, %0d conflict misses",
             n_requests, n_cycles, n_hit, n_cold, n_conflict);
    $display("covered: directed fills and evictions, back-to-back same-set traffic, "
             , "four idle/stall patterns");
    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sallru_pkg.sv
rtl/sallru_if.sv
rtl/sallru_ram.sv
rtl/sallru_way_sel.sv
rtl/set_assoc_lru_lookup_unit.sv
test/tb.sv
